// File: sv/spv_pkg.sv
// ----------------------------------------------------------------------------
// spv_pkg
// Shared types, widths, codes and arithmetic helpers of the sample playback
// voice.
// ----------------------------------------------------------------------------
`default_nettype none

package spv_pkg;

    localparam int SAMPLE_WORDS_DEF = 65536;
    localparam int MAX_CHANNELS_DEF = 2;

    localparam int SAMPLE_W    = 16;
    localparam int SCALED_W    = 17;
    localparam int FRAME_W     = 17;
    localparam int FRAC_W      = 16;
    localparam int STEP_W      = 24;
    localparam int VOL_W       = 16;
    localparam int CH_CNT_W    = 2;
    localparam int CMD_W       = 3;
    localparam int LOAD_ADDR_W = 16;
    localparam int WORD_IDX_W  = FRAME_W + 1;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int READ_IDX_W  = 2;

    localparam logic [VOL_W-1:0] UNITY_VOL = 16'h8000;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD   = 3'd0,
        CMD_TICK   = 3'd1,
        CMD_PLAY   = 3'd2,
        CMD_PAUSE  = 3'd3,
        CMD_REPLAY = 3'd4,
        CMD_STOP   = 3'd5
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CHANNEL_COUNT     = 3'd0,
        REG_STEP              = 3'd1,
        REG_SAMPLE_COUNT      = 3'd2,
        REG_LOOP_POINT        = 3'd3,
        REG_FADE_STEP         = 3'd4,
        REG_FADE_START_VOLUME = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic                  load_issue;
        logic                  read_issue;
        logic [READ_IDX_W-1:0] read_idx;
        logic                  play_set;
        logic                  play_clr;
        logic                  replay;
        logic                  stop;
        logic                  tick_eval;
        logic                  interp_mul;
        logic                  interp_sum;
        logic                  out_load;
    } spv_ctrl_t;

    typedef struct packed {
        logic play_flag;
        logic fade_stop;
        logic write_done;
        logic reads_done;
        logic out_busy;
    } spv_status_t;

    // word * volume / 32768, truncated toward zero
    function automatic logic signed [SCALED_W-1:0] scale_word(
        input logic signed [SAMPLE_W-1:0] word,
        input logic        [VOL_W-1:0]    vol
    );
        logic signed [32:0] prod;
        logic signed [32:0] adj;
        prod = 33'(word) * 33'($signed({1'b0, vol}));
        adj  = (prod < 0) ? prod + 33'sd32767 : prod;
        return SCALED_W'(adj >>> 15);
    endfunction

endpackage

`default_nettype wire

// File: sv/spv_if.sv
// ----------------------------------------------------------------------------
// spv_if
// Command and result channels of the sample playback voice.
// ----------------------------------------------------------------------------
`default_nettype none

interface spv_cmd_if import spv_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic        [CMD_W-1:0]       command;
    logic        [LOAD_ADDR_W-1:0] load_address;
    logic signed [SAMPLE_W-1:0]    load_sample;

    modport source (output valid, command, load_address, load_sample, input ready);
    modport sink   (input valid, command, load_address, load_sample, output ready);
endinterface

interface spv_res_if import spv_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       playing;
    logic                       ended;

    modport source (output valid, left_sample, right_sample, playing, ended, input ready);
    modport sink   (input valid, left_sample, right_sample, playing, ended, output ready);
endinterface

`default_nettype wire

// File: sv/sample_playback_voice_unit.sv
// ----------------------------------------------------------------------------
// sample_playback_voice_unit
// Interpolating playback voice over a loaded store of interleaved samples.
// ----------------------------------------------------------------------------
//  port   | role         | carries
//  -------+--------------+-----------------------------------------------
//  cmd    | sink         | command, load_address, load_sample
//  res    | source       | left_sample, right_sample, playing, ended
//  cfg_*  | write port   | six voice registers, index 0 to 5
//
//  A playing tick issues 2*MAX_CHANNELS store reads, one per cycle, through
//  an address-reduce/store/scale pipeline, then takes a multiply step and a
//  sum step in the interpolation lanes. A load waits for its store write;
//  a tick while stopped goes straight to result hand-off; others act in idle.
//  Reset returns voice state and registers to their defaults; the sample store is not cleared.
//  A stalled res side holds a finished result in the output register while
//  further commands are taken; the next result waits for that register.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_playback_voice_unit import spv_pkg::*; #(
    parameter int SAMPLE_WORDS = SAMPLE_WORDS_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    spv_cmd_if.sink                     cmd,
    spv_res_if.source                   res,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    spv_ctrl_t   ctrl;
    spv_status_t status;

    spv_ctrl #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_code  (cmd.command),
        .cmd_ready (cmd.ready),
        .ctrl      (ctrl),
        .status    (status)
    );

    spv_datapath #(
        .SAMPLE_WORDS (SAMPLE_WORDS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .load_address (cmd.load_address),
        .load_sample  (cmd.load_sample),
        .ctrl         (ctrl),
        .status       (status),
        .res_ready    (res.ready),
        .res_valid    (res.valid),
        .left_sample  (res.left_sample),
        .right_sample (res.right_sample),
        .playing      (res.playing),
        .ended        (res.ended)
    );

endmodule

`default_nettype wire

// File: sv/spv_store.sv
// ----------------------------------------------------------------------------
// spv_store
// Single-port sample word memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spv_store import spv_pkg::*; #(
    parameter  int WORDS = SAMPLE_WORDS_DEF,
    localparam int AW    = $clog2(WORDS)
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic                       re,
    input  wire logic [AW-1:0]              addr,
    input  wire logic signed [SAMPLE_W-1:0] wdata,
    output logic signed [SAMPLE_W-1:0]      rdata
);

    logic signed [SAMPLE_W-1:0] mem [WORDS];
    logic signed [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/spv_ctrl.sv
// ----------------------------------------------------------------------------
// spv_ctrl
// Command sequencer: decodes accepted items and steps the datapath through
// loads, tick evaluation, store reads, interpolation and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module spv_ctrl import spv_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    input  wire logic [CMD_W-1:0]  cmd_code,
    output logic                   cmd_ready,
    output spv_ctrl_t              ctrl,
    input  wire spv_status_t       status
);

    localparam int NREAD = 2 * MAX_CHANNELS;
    localparam int IDXW  = $clog2(NREAD);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_WAIT,
        S_TICK_EVAL,
        S_READ_ISSUE,
        S_READ_WAIT,
        S_INTERP_MUL,
        S_INTERP_SUM,
        S_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [IDXW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl       = '0;
        cmd_ready  = 1'b0;
        ctrl.read_idx = READ_IDX_W'(cnt_reg);
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    case (cmd_t'(cmd_code))
                        CMD_LOAD:
                        begin
                            ctrl.load_issue = 1'b1;
                            state_next      = S_LOAD_WAIT;
                        end
                        CMD_TICK:   state_next    = S_TICK_EVAL;
                        CMD_PLAY:   ctrl.play_set = 1'b1;
                        CMD_PAUSE:  ctrl.play_clr = 1'b1;
                        CMD_REPLAY: ctrl.replay   = 1'b1;
                        CMD_STOP:   ctrl.stop     = 1'b1;
                        default:    ;
                    endcase
                end
            end
            S_LOAD_WAIT:
            begin
                if (status.write_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_TICK_EVAL:
            begin
                ctrl.tick_eval = 1'b1;
                cnt_next       = '0;
                // no frame when stopped or when the fade runs out
                if (!status.play_flag || status.fade_stop)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_READ_ISSUE;
                end
            end
            S_READ_ISSUE:
            begin
                ctrl.read_issue = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == IDXW'(NREAD - 1))
                begin
                    state_next = S_READ_WAIT;
                end
            end
            S_READ_WAIT:
            begin
                if (status.reads_done)
                begin
                    state_next = S_INTERP_MUL;
                end
            end
            S_INTERP_MUL:
            begin
                ctrl.interp_mul = 1'b1;
                state_next      = S_INTERP_SUM;
            end
            S_INTERP_SUM:
            begin
                ctrl.interp_sum = 1'b1;
                state_next      = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/spv_datapath.sv
// ----------------------------------------------------------------------------
// spv_datapath
// Voice state, configuration registers, store address reduction pipeline,
// sample scaling, interpolation lanes and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spv_datapath import spv_pkg::*; #(
    parameter int SAMPLE_WORDS = SAMPLE_WORDS_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic        [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic        [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic        [LOAD_ADDR_W-1:0] load_address,
    input  wire logic signed [SAMPLE_W-1:0]    load_sample,
    input  wire spv_ctrl_t                     ctrl,
    output spv_status_t                        status,
    input  wire logic                          res_ready,
    output logic                               res_valid,
    output logic signed [SAMPLE_W-1:0]         left_sample,
    output logic signed [SAMPLE_W-1:0]         right_sample,
    output logic                               playing,
    output logic                               ended
);

    localparam int  AW    = $clog2(SAMPLE_WORDS);
    localparam int  XW    = WORD_IDX_W;
    localparam int  NREAD = 2 * MAX_CHANNELS;
    localparam bit  MULTI = (MAX_CHANNELS > 1);

    // configuration
    logic        [CH_CNT_W-1:0] ch_cnt_reg;
    logic        [STEP_W-1:0]   step_reg;
    logic        [FRAME_W-1:0]  sc_reg;
    logic        [FRAME_W-1:0]  lp_reg;
    logic signed [VOL_W-1:0]    fs_reg;
    logic        [VOL_W-1:0]    fsv_reg;

    // voice state
    logic [FRAME_W-1:0] pos_reg;
    logic [FRAC_W-1:0]  frac_reg;
    logic [VOL_W-1:0]   vol_reg;
    logic               fade_active_reg;
    logic               play_reg;

    // address pipeline
    logic [XW-1:0]         x0_reg, x1_reg, x2_reg, x0_next;
    logic                  t0_valid_reg, t1_valid_reg, t2_valid_reg, t3_valid_reg;
    logic                  t4_valid_reg;
    logic                  t0_wr_reg, t1_wr_reg, t2_wr_reg, t3_wr_reg;
    logic [READ_IDX_W-1:0] t0_idx_reg, t1_idx_reg, t2_idx_reg, t3_idx_reg, t4_idx_reg;
    logic [AW-1:0]         addr3_reg;
    logic signed [SAMPLE_W-1:0] wdata_reg;
    logic signed [SAMPLE_W-1:0] rdata;
    logic                  reads_done_reg;
    logic                  mem_we, mem_re;

    // lanes
    logic signed [SCALED_W-1:0] a_sc_reg [MAX_CHANNELS];
    logic signed [SCALED_W-1:0] b_sc_reg [MAX_CHANNELS];
    logic signed [34:0]         prod_reg [MAX_CHANNELS];
    logic signed [SAMPLE_W-1:0] lane_res [MAX_CHANNELS];

    // results
    logic signed [SAMPLE_W-1:0] res_left_reg, res_right_reg;
    logic                       res_playing_reg, res_ended_reg;
    logic signed [SAMPLE_W-1:0] out_left_reg, out_right_reg;
    logic                       out_playing_reg, out_ended_reg, out_valid_reg;

    // combinational helpers
    logic                  stereo;
    logic                  rd_is_b;
    logic [READ_IDX_W-1:0] rd_lane;
    logic [FRAME_W-1:0]    next_frame;
    logic [FRAME_W-1:0]    rd_frame;
    logic signed [17:0]    fade_sum;
    logic                  fade_stop;
    logic [VOL_W-1:0]      start_vol;
    logic [STEP_W:0]       total;
    logic [FRAME_W-1:0]    pos_adv;
    logic                  wrapped;
    logic                  end_stop;
    logic [FRAME_W-1:0]    pos_next;
    logic [FRAC_W-1:0]     frac_next;

    assign stereo = MULTI && ch_cnt_reg[1];

    // --------------------------------------------------------------------
    // word index of the load or read being issued
    // --------------------------------------------------------------------
    always_comb
    begin
        next_frame = (({1'b0, pos_reg} + 1'b1) < {1'b0, sc_reg}) ? pos_reg + 1'b1 : pos_reg;
        rd_is_b    = (ctrl.read_idx >= READ_IDX_W'(MAX_CHANNELS));
        rd_lane    = rd_is_b ? ctrl.read_idx - READ_IDX_W'(MAX_CHANNELS) : ctrl.read_idx;
        rd_frame   = rd_is_b ? next_frame : pos_reg;
        if (ctrl.load_issue)
        begin
            x0_next = XW'(load_address);
        end
        else if (stereo)
        begin
            x0_next = {rd_frame, 1'b0} + XW'(rd_lane);
        end
        else
        begin
            x0_next = XW'(rd_frame) + XW'(rd_lane);
        end
    end

    // --------------------------------------------------------------------
    // fade and position arithmetic
    // --------------------------------------------------------------------
    always_comb
    begin
        fade_sum  = $signed({2'b00, vol_reg}) + 18'(fs_reg);
        fade_stop = play_reg && fade_active_reg && (fade_sum <= 18'sd0);
        start_vol = (fsv_reg > UNITY_VOL) ? UNITY_VOL : fsv_reg;

        total     = (STEP_W+1)'(frac_reg) + (STEP_W+1)'(step_reg);
        pos_adv   = FRAME_W'((FRAME_W+1)'(pos_reg) + (FRAME_W+1)'(total[STEP_W:FRAC_W]));
        wrapped   = (pos_adv >= sc_reg);
        end_stop  = wrapped && (lp_reg > sc_reg);
        if (end_stop)
        begin
            pos_next  = '0;
            frac_next = '0;
        end
        else
        begin
            pos_next  = wrapped ? lp_reg : pos_adv;
            frac_next = total[FRAC_W-1:0];
        end
    end

    // --------------------------------------------------------------------
    // configuration and voice state
    // --------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_cnt_reg      <= CH_CNT_W'(1);
            step_reg        <= STEP_W'(65536);
            sc_reg          <= '0;
            lp_reg          <= '1;
            fs_reg          <= '0;
            fsv_reg         <= UNITY_VOL;
            pos_reg         <= '0;
            frac_reg        <= '0;
            vol_reg         <= UNITY_VOL;
            fade_active_reg <= 1'b0;
            play_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_CHANNEL_COUNT:     ch_cnt_reg <= cfg_data[CH_CNT_W-1:0];
                    REG_STEP:              step_reg   <= cfg_data[STEP_W-1:0];
                    REG_SAMPLE_COUNT:      sc_reg     <= cfg_data[FRAME_W-1:0];
                    REG_LOOP_POINT:        lp_reg     <= cfg_data[FRAME_W-1:0];
                    REG_FADE_STEP:         fs_reg     <= $signed(cfg_data[VOL_W-1:0]);
                    REG_FADE_START_VOLUME: fsv_reg    <= cfg_data[VOL_W-1:0];
                    default:               ;
                endcase
            end
            if (ctrl.play_set)
            begin
                play_reg <= 1'b1;
            end
            if (ctrl.play_clr)
            begin
                play_reg <= 1'b0;
            end
            if (ctrl.stop)
            begin
                play_reg <= 1'b0;
                pos_reg  <= '0;
                frac_reg <= '0;
            end
            if (ctrl.replay)
            begin
                pos_reg  <= '0;
                frac_reg <= '0;
                if (fs_reg != 0)
                begin
                    vol_reg         <= start_vol;
                    fade_active_reg <= 1'b1;
                end
                play_reg <= 1'b1;
            end
            if (ctrl.tick_eval && play_reg && fade_active_reg)
            begin
                if (fade_sum >= 18'sd32768)
                begin
                    vol_reg         <= UNITY_VOL;
                    fade_active_reg <= 1'b0;
                end
                else if (fade_stop)
                begin
                    vol_reg         <= UNITY_VOL;
                    fade_active_reg <= 1'b0;
                    play_reg        <= 1'b0;
                    pos_reg         <= '0;
                    frac_reg        <= '0;
                end
                else
                begin
                    vol_reg <= fade_sum[VOL_W-1:0];
                end
            end
            if (ctrl.interp_sum)
            begin
                pos_reg  <= pos_next;
                frac_reg <= frac_next;
                if (end_stop)
                begin
                    play_reg <= 1'b0;
                end
            end
        end
    end

    // --------------------------------------------------------------------
    // address pipeline tags
    // --------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_valid_reg   <= 1'b0;
            t1_valid_reg   <= 1'b0;
            t2_valid_reg   <= 1'b0;
            t3_valid_reg   <= 1'b0;
            t4_valid_reg   <= 1'b0;
            reads_done_reg <= 1'b0;
        end
        else
        begin
            t0_valid_reg   <= ctrl.load_issue || ctrl.read_issue;
            t1_valid_reg   <= t0_valid_reg;
            t2_valid_reg   <= t1_valid_reg;
            t3_valid_reg   <= t2_valid_reg;
            t4_valid_reg   <= mem_re;
            reads_done_reg <= t4_valid_reg && (t4_idx_reg == READ_IDX_W'(NREAD - 1));
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg     <= x0_next;
        t0_wr_reg  <= ctrl.load_issue;
        t0_idx_reg <= ctrl.read_idx;
        x1_reg     <= x0_reg;
        t1_wr_reg  <= t0_wr_reg;
        t1_idx_reg <= t0_idx_reg;
        x2_reg     <= x1_reg;
        t2_wr_reg  <= t1_wr_reg;
        t2_idx_reg <= t1_idx_reg;
        t3_wr_reg  <= t2_wr_reg;
        t3_idx_reg <= t2_idx_reg;
        t4_idx_reg <= t3_idx_reg;
        if (ctrl.load_issue)
        begin
            wdata_reg <= load_sample;
        end
    end

    // --------------------------------------------------------------------
    // word index modulo store size
    // --------------------------------------------------------------------
    generate
        if (SAMPLE_WORDS >= (2 ** XW))
        begin : g_no_wrap
            always_ff @(posedge clk)
            begin
                addr3_reg <= AW'(x2_reg);
            end
        end
        else
        begin : g_wrap
            // quotient estimate by reciprocal, low by at most one
            localparam int            RECIP   = (2 ** XW) / SAMPLE_WORDS;
            localparam logic [XW-1:0] RECIP_V = XW'(RECIP);
            localparam logic [XW-1:0] MOD_V   = XW'(SAMPLE_WORDS);

            logic [XW-1:0]   q1_reg, p2_reg;
            logic [2*XW-1:0] qprod, pprod;
            logic [XW:0]     rem, rem_fix;

            always_comb
            begin
                qprod   = {{XW{1'b0}}, x0_reg} * {{XW{1'b0}}, RECIP_V};
                pprod   = {{XW{1'b0}}, q1_reg} * {{XW{1'b0}}, MOD_V};
                rem     = {1'b0, x2_reg} - {1'b0, p2_reg};
                rem_fix = (rem >= {1'b0, MOD_V}) ? rem - {1'b0, MOD_V} : rem;
            end

            always_ff @(posedge clk)
            begin
                q1_reg    <= qprod[2*XW-1:XW];
                p2_reg    <= pprod[XW-1:0];
                addr3_reg <= rem_fix[AW-1:0];
            end
        end
    endgenerate

    assign mem_we = t3_valid_reg && t3_wr_reg;
    assign mem_re = t3_valid_reg && !t3_wr_reg;

    spv_store #(
        .WORDS (SAMPLE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (addr3_reg),
        .wdata (wdata_reg),
        .rdata (rdata)
    );

    // --------------------------------------------------------------------
    // scale and interpolate, one lane per channel
    // --------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < MAX_CHANNELS; l++)
        begin
            if (t4_valid_reg && (t4_idx_reg == READ_IDX_W'(l)))
            begin
                a_sc_reg[l] <= scale_word(rdata, vol_reg);
            end
            if (t4_valid_reg && (t4_idx_reg == READ_IDX_W'(MAX_CHANNELS + l)))
            begin
                b_sc_reg[l] <= scale_word(rdata, vol_reg);
            end
            if (ctrl.interp_mul)
            begin
                prod_reg[l] <= 35'(18'(b_sc_reg[l]) - 18'(a_sc_reg[l]))
                               * 35'($signed({1'b0, frac_reg}));
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < MAX_CHANNELS; l++)
        begin
            logic signed [35:0] num;
            logic signed [35:0] adj;
            num = 36'($signed({a_sc_reg[l], 16'h0000})) + 36'(prod_reg[l]);
            adj = (num < 0) ? num + 36'sd65535 : num;
            // skip the next frame entirely on a whole position
            lane_res[l] = (frac_reg == '0) ? SAMPLE_W'(a_sc_reg[l]) : SAMPLE_W'(adj >>> 16);
        end
    end

    // --------------------------------------------------------------------
    // result and output register
    // --------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ctrl.tick_eval)
        begin
            res_left_reg    <= '0;
            res_right_reg   <= '0;
            res_playing_reg <= 1'b0;
            res_ended_reg   <= fade_stop;
        end
        else if (ctrl.interp_sum)
        begin
            res_left_reg    <= lane_res[0];
            res_right_reg   <= stereo ? lane_res[MAX_CHANNELS-1] : '0;
            res_playing_reg <= 1'b1;
            res_ended_reg   <= end_stop;
        end
        if (ctrl.out_load)
        begin
            out_left_reg    <= res_left_reg;
            out_right_reg   <= res_right_reg;
            out_playing_reg <= res_playing_reg;
            out_ended_reg   <= res_ended_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign res_valid    = out_valid_reg;
    assign left_sample  = out_left_reg;
    assign right_sample = out_right_reg;
    assign playing      = out_playing_reg;
    assign ended        = out_ended_reg;

    always_comb
    begin
        status.play_flag  = play_reg;
        status.fade_stop  = fade_stop;
        status.write_done = mem_we;
        status.reads_done = reads_done_reg;
        status.out_busy   = out_valid_reg && !res_ready;
    end

endmodule

`default_nettype wire
